// ===== hdl/v6pfx_pkg.sv =====
// shared constants, codes and types of the ipv6 prefix wire parser
`timescale 1ns / 1ps

package v6pfx_pkg;

  // address bytes a prefix may carry; the length limit follows from it
  localparam int ADDRESS_BYTES = 16;
  localparam int ADDR_BITS = ADDRESS_BYTES * 8;
  localparam int IDX_W = $clog2(ADDRESS_BYTES);
  localparam logic [8:0] LENGTH_LIMIT = 9'(ADDR_BITS);

  // width of the output address fields and of the bytes-used field
  localparam int OUT_ADDR_BITS = 128;
  localparam int USED_W = 5;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_GATHER = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // one finished prefix, address still unmasked
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           len;
    logic [USED_W-1:0]    used;
    status_t              status;
  } entry_t;

endpackage

// ===== hdl/v6pfx_if.sv =====
// valid/ready channels for wire bytes and decoded prefixes
`timescale 1ns / 1ps

interface v6pfx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_buffer;

  modport source (output valid, output byte_value, output end_of_buffer, input ready);
  modport sink (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

interface v6pfx_prefix_if;
  logic        valid;
  logic        ready;
  logic [63:0] address_upper;
  logic [63:0] address_lower;
  logic [7:0]  prefix_length;
  logic [4:0]  bytes_consumed;
  logic [1:0]  status;

  modport source (output valid, output address_upper, output address_lower,
                  output prefix_length, output bytes_consumed, output status,
                  input ready);
  modport sink (input valid, input address_upper, input address_lower,
                input prefix_length, input bytes_consumed, input status,
                output ready);
endinterface

// ===== hdl/v6pfx_front.sv =====
// front end: takes wire bytes, tracks the prefix phase and gathers address bytes
`timescale 1ns / 1ps

module v6pfx_front (
  input  logic              clk,
  input  logic              rst,
  v6pfx_byte_if.sink        wire_bytes,
  input  logic              queue_full,
  output logic              push,
  output v6pfx_pkg::entry_t entry
);
  import v6pfx_pkg::*;

  phase_t           phase, phase_next;
  logic [7:0]       held_length, held_length_next;
  logic [IDX_W-1:0] byte_idx, byte_idx_next;
  logic [7:0]       gathered [ADDRESS_BYTES];

  logic                 fire;
  logic                 too_long;
  logic                 last_byte;
  logic                 eob;
  logic [7:0]           b;
  logic [7:0]           last_idx;
  logic [ADDR_BITS-1:0] addr_now;
  logic [USED_W-1:0]    used_now;

  assign wire_bytes.ready = !queue_full;
  assign fire      = wire_bytes.valid && wire_bytes.ready;
  assign b         = wire_bytes.byte_value;
  assign eob       = wire_bytes.end_of_buffer;
  assign too_long  = {1'b0, b} > LENGTH_LIMIT;
  assign last_idx  = (held_length - 8'd1) >> 3;
  assign last_byte = byte_idx == last_idx[IDX_W-1:0];
  assign used_now  = USED_W'(byte_idx) + USED_W'(2);

  // gathered bytes with the incoming byte dropped into its slot
  always_comb begin
    for (int i = 0; i < ADDRESS_BYTES; i++) begin
      addr_now[ADDR_BITS-1-8*i -: 8] = (IDX_W'(i) == byte_idx) ? b : gathered[i];
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_GATHER: begin
        if (fire && (last_byte || eob)) phase_next = PH_LENGTH;
      end
      PH_SKIP: begin
        if (fire && eob) phase_next = PH_LENGTH;
      end
      default: begin
        phase_next = PH_LENGTH;
        if (fire) begin
          if (too_long) begin
            phase_next = eob ? PH_LENGTH : PH_SKIP;
          end else if (b != 8'd0 && !eob) begin
            phase_next = PH_GATHER;
          end
        end
      end
    endcase
  end

  // requests and held values
  always_comb begin
    push             = 1'b0;
    entry.addr       = addr_now;
    entry.len        = held_length;
    entry.used       = used_now;
    entry.status     = ST_OK;
    held_length_next = held_length;
    byte_idx_next    = byte_idx;
    unique case (phase)
      PH_GATHER: begin
        if (fire) begin
          byte_idx_next = byte_idx + 1'b1;
          if (last_byte) begin
            push = 1'b1;
          end else if (eob) begin
            push         = 1'b1;
            entry.status = ST_TRUNC;
          end
        end
      end
      PH_SKIP: begin
        byte_idx_next = byte_idx;
      end
      default: begin
        byte_idx_next = '0;
        if (fire) begin
          entry.used = USED_W'(1);
          if (too_long) begin
            push         = 1'b1;
            entry.len    = 8'd0;
            entry.status = ST_INVALID;
          end else begin
            held_length_next = b;
            entry.len        = b;
            if (b == 8'd0) begin
              push = 1'b1;
            end else if (eob) begin
              push         = 1'b1;
              entry.status = ST_TRUNC;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LENGTH;
      held_length <= 8'd0;
      byte_idx    <= '0;
    end else begin
      phase       <= phase_next;
      held_length <= held_length_next;
      byte_idx    <= byte_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && phase == PH_GATHER) begin
      gathered[byte_idx] <= b;
    end
  end

  // gather index never runs past the final address byte
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GATHER |-> byte_idx <= last_idx[IDX_W-1:0])
    else $error("gather index beyond last address byte");

  // a result always closes the prefix
  a_push_closes: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == PH_LENGTH || phase == PH_SKIP)
    else $error("still gathering after a result");

  // a truncated result never claims a whole prefix
  a_trunc_used: assert property (@(posedge clk) disable iff (rst)
    push && entry.status == ST_TRUNC |-> entry.used <= USED_W'(ADDRESS_BYTES))
    else $error("truncated result reports too many bytes");

endmodule

// ===== hdl/v6pfx_queue.sv =====
// short request queue between front and back
`timescale 1ns / 1ps

module v6pfx_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  v6pfx_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output v6pfx_pkg::entry_t pop_entry,
  output logic              not_empty
);
  import v6pfx_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("request popped from an empty queue");

endmodule

// ===== hdl/v6pfx_back.sv =====
// back end: masks the gathered address and holds the result for the sink
`timescale 1ns / 1ps

module v6pfx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              has_entry,
  input  v6pfx_pkg::entry_t entry,
  output logic              pop,
  v6pfx_prefix_if.source    prefixes
);
  import v6pfx_pkg::*;

  logic                     out_valid;
  logic [ADDR_BITS-1:0]     keep;
  logic [OUT_ADDR_BITS-1:0] wide;

  assign pop = has_entry && (!out_valid || prefixes.ready);
  assign prefixes.valid = out_valid;

  // keep bit j (counted from the first wire bit) while j is under the length
  always_comb begin
    for (int j = 0; j < ADDR_BITS; j++) begin
      keep[ADDR_BITS-1-j] = 9'(j) < {1'b0, entry.len};
    end
  end

  always_comb begin
    wide = '0;
    if (entry.status == ST_OK) begin
      wide[OUT_ADDR_BITS-1 -: ADDR_BITS] = entry.addr & keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (prefixes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prefixes.address_upper  <= wide[127:64];
      prefixes.address_lower  <= wide[63:0];
      prefixes.prefix_length  <= entry.len;
      prefixes.bytes_consumed <= entry.used;
      prefixes.status         <= entry.status;
    end
  end

endmodule

// ===== hdl/ipv6_prefix_wire_parser.sv =====
// top level of the ipv6 prefix wire parser
`timescale 1ns / 1ps

// Decodes IPv6 prefixes in wire form (a length byte, then ceil(length/8)
// address bytes) from a stream of one byte per request, and gives one
// result per prefix: the address with bits past the length cleared, the
// length and the bytes used. A length above 128 gives an invalid status
// and the bytes up to the end-of-buffer mark are dropped; an end mark
// before the last address byte gives a truncated status. The block takes
// one byte every cycle while the queue is not full. A result is written
// into the queue by the edge that takes the byte completing it, and then
// loads into the output register once that is free. The front end tracks
// the phase and gathers bytes into a 16-byte register; finished prefixes
// go through a two-entry queue to the back end, which masks the address
// and holds it in an output register. Input ready drops only once the
// queue is full, that is with one stalled result in the output register
// and two more waiting behind it; reset needs no clearing pass.
module ipv6_prefix_wire_parser (
  input logic            clk,
  input logic            rst,
  v6pfx_byte_if.sink     wire_bytes,
  v6pfx_prefix_if.source prefixes
);
  import v6pfx_pkg::*;

  // front to queue
  logic   push;
  entry_t push_entry;
  logic   queue_full;

  // queue to back
  logic   pop;
  entry_t pop_entry;
  logic   has_entry;

  // phase tracking and byte gathering
  v6pfx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wire_bytes (wire_bytes),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  // decouples the byte side from output stalls
  v6pfx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (has_entry)
  );

  // masking and output register
  v6pfx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .has_entry (has_entry),
    .entry     (pop_entry),
    .pop       (pop),
    .prefixes  (prefixes)
  );

endmodule

// ===== test/ipv6_prefix_wire_parser_tb.sv =====
// testbench for the ipv6 prefix wire parser: byte stream stimulus, decode prediction, checks
`timescale 1ns / 1ps

module ipv6_prefix_wire_parser_tb;
  import v6pfx_pkg::*;

  // generous bound, far above the slowest correct run
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 650;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_byte_t;

  logic clk;
  logic rst;

  v6pfx_byte_if   byte_ch ();
  v6pfx_prefix_if prefix_ch ();

  ipv6_prefix_wire_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .wire_bytes(byte_ch),
    .prefixes  (prefix_ch)
  );

  // bytes waiting to be offered, and decoded prefixes still owed by the block
  wire_byte_t wire_queue[$];
  entry_t     owed_prefixes[$];

  int  bytes_queued = 0;
  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  byte_fired = 1'b0;

  // decoder state, tracked alongside the block
  phase_t     dec_phase = PH_LENGTH;
  logic [7:0] dec_length = 8'd0;
  logic [4:0] dec_left = 5'd0;
  logic [7:0] dec_bytes[16] = '{default: 8'h00};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the decoder by one wire byte; returns 1 when a prefix result is due
  function automatic bit decode_byte(input logic [7:0] b, input logic eob,
                                     output entry_t res);
    int         octs;
    int         idx;
    logic [7:0] tail;
    res = '0;
    decode_byte = 1'b0;
    case (dec_phase)
      PH_SKIP: begin
        // dropping bytes after an oversized length until the end mark
        if (eob) dec_phase = PH_LENGTH;
      end
      PH_GATHER: begin
        octs = (int'(dec_length) + 7) / 8;
        idx = octs - int'(dec_left);
        dec_bytes[idx] = b;
        dec_left = dec_left - 5'd1;
        if (dec_left == 5'd0) begin
          // complete: pack bytes msb-first, clear bits past the length
          dec_phase = PH_LENGTH;
          for (int i = 0; i < octs; i++) begin
            tail = dec_bytes[i];
            if (i == octs - 1 && dec_length % 8 != 0)
              tail = tail & (8'hff << (8 - dec_length % 8));
            res.addr[127 - 8 * i -: 8] = tail;
          end
          res.len = dec_length;
          res.used = 5'(1 + octs);
          res.status = ST_OK;
          decode_byte = 1'b1;
        end else if (eob) begin
          // end mark before the last address byte
          dec_phase = PH_LENGTH;
          dec_left = 5'd0;
          res.len = dec_length;
          res.used = 5'(idx + 2);
          res.status = ST_TRUNC;
          decode_byte = 1'b1;
        end
      end
      default: begin
        dec_phase = PH_LENGTH;
        res.used = 5'd1;
        decode_byte = 1'b1;
        if (b > ADDR_BITS) begin
          res.status = ST_INVALID;
          if (!eob) dec_phase = PH_SKIP;
        end else begin
          dec_length = b;
          if (b == 8'd0) begin
            res.status = ST_OK;
          end else if (eob) begin
            res.len = b;
            res.status = ST_TRUNC;
          end else begin
            dec_left = 5'((int'(b) + 7) / 8);
            dec_phase = PH_GATHER;
            decode_byte = 1'b0;
          end
        end
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic last);
    wire_queue.push_back('{value: value, last: last});
    bytes_queued++;
  endtask

  // one random prefix: mostly well formed, some cut short, some oversized
  task automatic queue_random_prefix();
    int pick;
    int len;
    int octs;
    int cut;
    int junk;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      len = $urandom_range(ADDR_BITS + 1, 255);
      if ($urandom_range(0, 3) == 0) begin
        push_byte(8'(len), 1'b1);
      end else begin
        push_byte(8'(len), 1'b0);
        junk = $urandom_range(0, 4);
        repeat (junk) push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
      end
    end else begin
      if (pick < 16) len = 0;
      else if (pick < 26) len = ADDR_BITS;
      else len = $urandom_range(1, ADDR_BITS);
      octs = (len + 7) / 8;
      // cut point: 0 marks the length byte, octs the last needed byte
      cut = ($urandom_range(0, 99) < 14) ? $urandom_range(0, octs) : -1;
      push_byte(8'(len), cut == 0);
      for (int k = 1; k <= octs; k++) begin
        if (cut >= 0 && k > cut) break;
        push_byte(8'($urandom), cut == k);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // driver: a request is held until taken, then the next one may follow an idle gap
  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      prefix_ch.ready <= 1'b0;
    end else begin
      if (!byte_ch.valid || byte_fired) begin
        if (wire_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          byte_ch.valid <= 1'b1;
          byte_ch.byte_value <= wire_queue[0].value;
          byte_ch.end_of_buffer <= wire_queue[0].last;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
      prefix_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: predict on every taken byte, check every taken prefix
  always @(posedge clk) begin
    entry_t want;
    if (rst) begin
      byte_fired <= 1'b0;
    end else begin
      byte_fired <= byte_ch.valid && byte_ch.ready;
      if (byte_ch.valid && byte_ch.ready) begin
        void'(wire_queue.pop_front());
        if (decode_byte(byte_ch.byte_value, byte_ch.end_of_buffer, want))
          owed_prefixes.push_back(want);
      end
      if (prefix_ch.valid && prefix_ch.ready) begin
        if (owed_prefixes.size() == 0) begin
          errors++;
          $display("%0t: unexpected prefix, expected none, got %h %h len %0d used %0d st %0d",
                   $time, prefix_ch.address_upper, prefix_ch.address_lower,
                   prefix_ch.prefix_length, prefix_ch.bytes_consumed, prefix_ch.status);
        end else begin
          want = owed_prefixes.pop_front();
          check_field("address_upper", want.addr[127:64], prefix_ch.address_upper);
          check_field("address_lower", want.addr[63:0], prefix_ch.address_lower);
          check_field("prefix_length", 64'(want.len), 64'(prefix_ch.prefix_length));
          check_field("bytes_consumed", 64'(want.used), 64'(prefix_ch.bytes_consumed));
          check_field("status", 64'(want.status), 64'(prefix_ch.status));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus sequencing through the idling phases
  initial begin
    int target;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.byte_value = 8'h00;
    byte_ch.end_of_buffer = 1'b0;
    prefix_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero length prefix
    push_byte(8'd0, 1'b0);
    // oversized length, junk skipped up to the end mark
    push_byte(8'd129, 1'b0);
    push_byte(8'h5a, 1'b0);
    push_byte(8'hff, 1'b1);
    // oversized length carrying the end mark itself
    push_byte(8'd255, 1'b1);
    // end mark on the length byte
    push_byte(8'd9, 1'b1);
    // full 128-bit prefix, all ones
    push_byte(8'd128, 1'b0);
    repeat (16) push_byte(8'hff, 1'b0);
    // partial tail byte; older gathered bytes must not leak through
    push_byte(8'd7, 1'b0);
    push_byte(8'hff, 1'b0);
    // end mark on the last needed byte still completes
    push_byte(8'd12, 1'b0);
    push_byte(8'hab, 1'b0);
    push_byte(8'hcd, 1'b1);
    // end mark in the middle of the address
    push_byte(8'd40, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      target = bytes_queued + RANDOM_BYTES / 4;
      while (bytes_queued < target) queue_random_prefix();
      while (wire_queue.size() != 0) @(posedge clk);
    end

    while (owed_prefixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
